[rtl/core/pmu_pkg.sv]
// Shared types and constants for the pheromone matrix update block.
package pmu_pkg;

	localparam logic [2:0] CMD_INIT  = 3'd0;
	localparam logic [2:0] CMD_LOCAL = 3'd1;
	localparam logic [2:0] CMD_EVAP  = 3'd2;
	localparam logic [2:0] CMD_TOUR  = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic [1:0] REG_RATE  = 2'd0;
	localparam logic [1:0] REG_INIT  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [16:0] RATE_ONE = 17'd65536;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [4:0]  row;
		logic [4:0]  col;
		logic [5:0]  city_id;
		logic        first_of_tour;
		logic [31:0] tour_cost;
	} in_req_t;

	typedef struct packed {
		logic [31:0] level;
		logic [1:0]  status;
	} out_req_t;

	// classified request from the front end; indices are 6 bits to cover MAX_CITIES up to 64
	typedef struct packed {
		logic [2:0]  cmd;
		logic        bad;
		logic        first;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [31:0] cost;
	} job_t;

endpackage

[rtl/core/pmu_front.sv]
// Front end: accepts requests, checks indices, tracks the previous tour city.
module pmu_front import pmu_pkg::*; #(
	parameter int MAX_CITIES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_req_t       in_data,
	input  logic [6:0]    n_cities,
	output logic          job_valid,
	input  logic          job_ready,
	output job_t          job
);

	logic [5:0] prev_q;
	logic [6:0] k;
	logic       id_bad;
	job_t       j;

	logic [1:0] cnt_q;
	job_t       fifo_q [2];
	logic       wp_q, rp_q;

	assign in_ready = (cnt_q != 2'd2);
	assign k = {1'b0, in_data.city_id} - 7'd1;
	assign id_bad = (in_data.city_id == 6'd0) || ({1'b0, in_data.city_id} > n_cities);

	always_comb begin
		j = '0;
		j.cmd = in_data.cmd;
		j.first = in_data.first_of_tour;
		j.cost = in_data.tour_cost;
		j.row = {1'b0, in_data.row};
		j.col = {1'b0, in_data.col};
		case (in_data.cmd)
			CMD_LOCAL, CMD_READ: begin
				j.bad = ({2'b0, in_data.row} >= n_cities) || ({2'b0, in_data.col} >= n_cities);
			end
			CMD_TOUR: begin
				j.row = prev_q;
				j.col = k[5:0];
				j.bad = id_bad || (!in_data.first_of_tour && ({1'b0, prev_q} >= n_cities));
			end
			default: j.bad = 1'b0;
		endcase
	end

	wire push = in_valid && in_ready;
	wire pop  = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push && in_data.cmd == CMD_TOUR && !j.bad)
				prev_q <= k[5:0];
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= j;
	end

	assign job_valid = (cnt_q != 2'd0);
	assign job = fifo_q[rp_q];

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("accepted into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !job_valid) else $error("job from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		n_cities <= 7'(MAX_CITIES)) else $error("city count above maximum");

endmodule

[rtl/core/pmu_back.sv]
// Back end: matrix memory, sweeps, multiply-accumulate and serial divider.
module pmu_back import pmu_pkg::*; #(
	parameter int MAX_CITIES = 32,
	parameter int IW = $clog2(MAX_CITIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  job_t          job,
	input  logic [16:0]   rate,
	input  logic [31:0]   init_level,
	input  logic [6:0]    n_cities,
	output logic          out_valid,
	input  logic          out_ready,
	output out_req_t      out_data
);

	localparam int AW = 2 * IW;
	localparam int DEPTH = 1 << AW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_ADD   = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_SUM   = 4'd5;
	localparam logic [3:0] S_OUT   = 4'd6;
	localparam logic [3:0] S_SWRD  = 4'd7;
	localparam logic [3:0] S_SWMUL = 4'd8;
	localparam logic [3:0] S_SWWR  = 4'd9;

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] addr;
	logic        we;
	logic [31:0] wd;

	logic [3:0]  st_q;
	job_t        job_q;
	logic [IW-1:0] i_q, j_q;
	logic [16:0] r;
	logic [16:0] omr;
	logic [48:0] m1_q;
	logic [48:0] m2_q;
	logic [49:0] acc;
	logic [33:0] d_q;
	logic [32:0] rem_q;
	logic [5:0]  bit_q;
	logic        out_valid_q;
	out_req_t    out_q;

	assign r = (rate > RATE_ONE) ? RATE_ONE : rate;
	assign omr = RATE_ONE - r;
	assign job_ready = (st_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// sweep address or job address
	always_comb begin
		if (st_q == S_SWRD || st_q == S_SWMUL || st_q == S_SWWR)
			addr = {i_q, j_q};
		else
			addr = {job_q.row[IW-1:0], job_q.col[IW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	wire [IW:0] i_nx = {1'b0, i_q} + 1'b1;
	wire [IW:0] j_nx = {1'b0, j_q} + 1'b1;
	wire        j_end = ({{(6-IW){1'b0}}, j_nx} >= n_cities);
	wire        i_end = ({{(6-IW){1'b0}}, i_nx} >= n_cities);
	wire [33:0] rsh = {r, 16'b0} >> bit_q;
	wire [32:0] trial = {rem_q[31:0], rsh[0]};
	wire [32:0] sum = {1'b0, rd_q} + {1'b0, d_q[31:0]};

	always_comb begin
		we = 1'b0;
		wd = 32'd0;
		acc = {1'b0, m1_q} + {1'b0, m2_q} + 50'd32768;
		case (st_q)
			S_ADD: begin
				we = 1'b1;
				wd = (acc[49:16] > 34'hFFFFFFFF) ? 32'hFFFFFFFF : acc[47:16];
			end
			S_SUM: begin
				we = 1'b1;
				wd = (sum[32] || d_q[33:32] != 2'b0) ? 32'hFFFFFFFF : sum[31:0];
			end
			S_SWWR: begin
				// init also clears the diagonal; evaporate leaves it alone
				we = (i_q != j_q) || (job_q.cmd == CMD_INIT);
				wd = (i_q == j_q) ? 32'd0 : (job_q.cmd == CMD_INIT ? init_level : acc[47:16]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (job_valid && job_ready) begin
					if (job.bad || (job.cmd == CMD_TOUR && job.first) || job.cmd > CMD_READ
						|| ((job.cmd == CMD_INIT || job.cmd == CMD_EVAP) && n_cities == 7'd0)) begin
						out_valid_q <= 1'b1;
					end else if (job.cmd == CMD_INIT || job.cmd == CMD_EVAP) begin
						st_q <= S_SWRD;
					end else begin
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= (job_q.cmd == CMD_READ) ? S_OUT : (job_q.cmd == CMD_LOCAL ? S_MUL : S_DIV);
				S_MUL: st_q <= S_ADD;
				S_ADD: begin st_q <= S_IDLE; out_valid_q <= 1'b1; end
				S_DIV: if (bit_q == 6'd0) st_q <= S_SUM;
				S_SUM: begin st_q <= S_IDLE; out_valid_q <= 1'b1; end
				S_OUT: begin st_q <= S_IDLE; out_valid_q <= 1'b1; end
				S_SWRD: st_q <= S_SWMUL;
				S_SWMUL: st_q <= S_SWWR;
				S_SWWR: begin
					if (j_end && i_end) begin
						st_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end else st_q <= S_SWRD;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				job_q <= job;
				i_q <= '0;
				j_q <= '0;
				d_q <= '0;
				rem_q <= '0;
				bit_q <= 6'd33;
				if (job_valid && job_ready)
					out_q <= '{level: 32'd0, status: job.bad ? ST_RANGE : ST_OK};
			end
			S_RD: ;
			// rd_q holds the entry from here on
			S_MUL: begin
				m1_q <= {32'd0, omr} * {17'd0, rd_q};
				m2_q <= {32'd0, r} * {17'd0, init_level};
			end
			S_ADD: out_q <= '{level: wd, status: ST_OK};
			S_DIV: begin
				// restoring division, one quotient bit per cycle
				if (job_q.cost == 32'd0) begin
					d_q <= (r != 17'd0) ? 34'h200000000 : 34'd0;
					bit_q <= 6'd0;
				end else begin
					if (trial >= {1'b0, job_q.cost}) begin
						rem_q <= trial - {1'b0, job_q.cost};
						d_q <= {d_q[32:0], 1'b1};
					end else begin
						rem_q <= trial;
						d_q <= {d_q[32:0], 1'b0};
					end
					bit_q <= bit_q - 6'd1;
				end
			end
			S_SUM: out_q <= '{level: wd,
				status: (sum[32] || d_q[33:32] != 2'b0) ? ST_SAT : ST_OK};
			S_OUT: out_q <= '{level: rd_q, status: ST_OK};
			S_SWRD: ;
			S_SWMUL: begin
				m1_q <= {32'd0, omr} * {17'd0, rd_q};
				m2_q <= '0;
			end
			S_SWWR: begin
				if (j_end) begin
					j_q <= '0;
					i_q <= i_nx[IW-1:0];
				end else j_q <= j_nx[IW-1:0];
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !job_ready) else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SWWR && i_q == j_q && job_q.cmd == CMD_EVAP) |-> !we)
		else $error("diagonal written in evaporate sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");

endmodule

[rtl/core/pheromone_matrix_update.sv]
// A tour step takes 34 divider steps; speed is set by the one-bit-a-cycle divider and the
//   single-port matrix memory.
// Init and evaporate sweep n*n entries, each through the read, multiply and write states.
// Throughput: one request in the back end at a time; the next starts the cycle after the
//   result is taken. A two-entry queue decouples the front end.
// Reset: asynchronous, clears control and previous city; matrix contents undefined until init.
module pheromone_matrix_update import pmu_pkg::*; #(
	parameter int MAX_CITIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_req_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = $clog2(MAX_CITIES);

	logic [16:0] rate_q;
	logic [31:0] init_q;
	logic [5:0]  count_q;
	logic [6:0]  n_cities;
	logic        job_valid, job_ready;
	job_t        job;

	assign n_cities = ({1'b0, count_q} > 7'(MAX_CITIES)) ? 7'(MAX_CITIES) : {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 17'd6554;
			init_q <= 32'd65536;
			count_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE:  rate_q <= cfg_data[16:0];
				REG_INIT:  init_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	pmu_front #(.MAX_CITIES(MAX_CITIES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .n_cities,
		.job_valid, .job_ready, .job
	);

	pmu_back #(.MAX_CITIES(MAX_CITIES), .IW(IW)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.rate(rate_q), .init_level(init_q), .n_cities,
		.out_valid, .out_ready, .out_data
	);

endmodule
